>>> src/steering_force_feedback_unit_macros.svh
// Assertion macros shared by the steering force feedback unit.
`ifndef STEERING_FORCE_FEEDBACK_UNIT_MACROS_SVH
`define STEERING_FORCE_FEEDBACK_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SFFU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SFFU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sffu_pkg.sv
// Types, constants and sine table builder for the steering force feedback unit.
package sffu_pkg;

  // Default sizes
  localparam int SINE_ENTRIES_DEF = 256;
  localparam int PHASE_BITS_DEF   = 16;

  // Field and bus widths
  localparam int DATA_W    = 16;
  localparam int AMP_W     = 15;
  localparam int STEP_W    = 16;
  localparam int MODE_W    = 3;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;

  // Mode flag bit positions
  localparam int MODE_EN     = 0;
  localparam int MODE_HOLD   = 1;
  localparam int MODE_CENTER = 2;

  // Fixed-point constants
  localparam int     CENTER_GAIN = 19661;   // 0.6 in Q0.15
  localparam int     FRAC_BITS   = 15;
  localparam int     FORCE_MAX   = 32767;
  localparam int     FORCE_MIN   = -32768;
  localparam longint TWO_PI_Q28  = 64'sd1686629713;
  localparam longint ONE_Q28     = 64'sd268435456;
  localparam longint HALF_Q28    = 64'sd134217728;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_MODE_FLAGS  = 3'd0,
    REG_RIGHT_LIMIT = 3'd1,
    REG_LEFT_LIMIT  = 3'd2,
    REG_TARGET      = 3'd3,
    REG_CONST_FORCE = 3'd4,
    REG_VIB_AMP     = 3'd5,
    REG_PHASE_STEP  = 3'd6
  } reg_idx_t;

  // Configuration register bank contents
  typedef struct packed {
    logic [MODE_W-1:0]        mode_flags;
    logic signed [DATA_W-1:0] right_limit;
    logic signed [DATA_W-1:0] left_limit;
    logic signed [DATA_W-1:0] target_angle;
    logic signed [DATA_W-1:0] constant_force;
    logic [AMP_W-1:0]         vib_amp;
    logic [STEP_W-1:0]        phase_step;
  } cfg_t;

  // One Taylor step: multiply by angle squared, back to Q28
  function automatic longint taylor_mul(input longint term, input longint a2);
    return (term * a2) >> 28;
  endfunction

  // sin of a Q28 angle in [0, pi], Q28 result; used only at elaboration
  function automatic longint sine_q28(input longint a);
    longint a2;
    longint term;
    longint sum;
    a2   = (a * a) >> 28;
    term = a;
    sum  = a;
    term = taylor_mul(term, a2) / 6;   sum -= term;
    term = taylor_mul(term, a2) / 20;  sum += term;
    term = taylor_mul(term, a2) / 42;  sum -= term;
    term = taylor_mul(term, a2) / 72;  sum += term;
    term = taylor_mul(term, a2) / 110; sum -= term;
    term = taylor_mul(term, a2) / 156; sum += term;
    term = taylor_mul(term, a2) / 210; sum -= term;
    term = taylor_mul(term, a2) / 272; sum += term;
    term = taylor_mul(term, a2) / 342; sum -= term;
    term = taylor_mul(term, a2) / 420; sum += term;
    term = taylor_mul(term, a2) / 506; sum -= term;
    term = taylor_mul(term, a2) / 600; sum += term;
    return sum;
  endfunction

  // Table entry from a folded angle and its sign, scaled to 32767
  function automatic logic signed [DATA_W-1:0] sine_entry(input longint ang,
                                                          input bit neg_in);
    longint s;
    longint mag;
    bit     neg;
    neg = neg_in;
    s   = sine_q28(ang);
    if (s < 0) begin
      s   = -s;
      neg = !neg;
    end
    if (s > ONE_Q28) begin
      s = ONE_Q28;
    end
    mag = (s * 64'sd32767 + HALF_Q28) >> 28;
    return neg ? DATA_W'(-mag) : DATA_W'(mag);
  endfunction

endpackage

>>> src/steering_force_feedback_unit.sv
// Steering force feedback unit: top level with input stage and output register.
// The input stage and result register lie between input transfer and result valid.
// One sample per cycle unless stalled; the sine entry is prefetched from phase_r.
// Samples taken while feedback is disabled advance the phase but give no result.
// Reset (rst_n low, synchronous) clears stage valid bits and phase and resets config.
`include "steering_force_feedback_unit_macros.svh"

module steering_force_feedback_unit #(
  parameter int SINE_ENTRIES = sffu_pkg::SINE_ENTRIES_DEF,
  parameter int PHASE_BITS   = sffu_pkg::PHASE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,    // [15:0] steer_sample
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,   // [15:0] force_command
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sffu_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [sffu_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [sffu_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int DW = sffu_pkg::DATA_W;

  sffu_pkg::cfg_t        cfg;
  logic                  in_xfer;
  logic                  s1_adv;
  logic                  s1_valid_r;
  logic signed [DW-1:0]  s1_steer_r;
  logic signed [DW-1:0]  s1_center_r;
  logic signed [DW-1:0]  s1_vib_r;
  logic signed [DW-1:0]  steer_in;
  logic signed [DW-1:0]  sine_q;
  logic signed [32:0]    center_prod;
  logic signed [32:0]    vib_prod;
  logic signed [DW-1:0]  center_nxt;
  logic signed [DW-1:0]  vib_nxt;
  logic signed [DW-1:0]  force_q;
  logic                  out_valid_r;
  logic [DW-1:0]         out_data_r;

  sffu_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sffu_vib #(
    .SINE_ENTRIES (SINE_ENTRIES),
    .PHASE_BITS   (PHASE_BITS)
  ) u_vib (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (in_xfer),
    .phase_step (cfg.phase_step),
    .sine_q     (sine_q)
  );

  // Handshake: stage 1 moves on when the result register is free or drained
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  // Input-side products, rounded half up: steer * 0.6 and sine * amplitude
  assign steer_in    = in_tdata;
  assign center_prod = 33'(steer_in) * 33'(sffu_pkg::CENTER_GAIN)
                       + 33'(1 << (sffu_pkg::FRAC_BITS - 1));
  assign vib_prod    = 33'(sine_q) * $signed({18'd0, cfg.vib_amp})
                       + 33'(1 << (sffu_pkg::FRAC_BITS - 1));
  assign center_nxt  = DW'(center_prod >>> sffu_pkg::FRAC_BITS);
  assign vib_nxt     = DW'(vib_prod >>> sffu_pkg::FRAC_BITS);

  sffu_force u_force (
    .cfg     (cfg),
    .steer   (s1_steer_r),
    .center  (s1_center_r),
    .vib     (s1_vib_r),
    .force_q (force_q)
  );

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r && cfg.mode_flags[sffu_pkg::MODE_EN];
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_steer_r  <= steer_in;
      s1_center_r <= center_nxt;
      s1_vib_r    <= vib_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      out_data_r <= force_q;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `SFFU_ASSERT_NXT(a_s1_holds, s1_valid_r && !s1_adv, s1_valid_r, "stage 1 sample lost while stalled")
  `SFFU_ASSERT_NXT(a_in_loads, in_xfer, s1_valid_r, "accepted sample not staged")
  `SFFU_ASSERT_IMP(a_out_src, $rose(out_tvalid), $past(s1_valid_r) && $past(cfg.mode_flags[sffu_pkg::MODE_EN]), "result without an enabled staged sample")

endmodule

>>> src/sffu_cfg.sv
// APB-style configuration register bank.
module sffu_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [sffu_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [sffu_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [sffu_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output sffu_pkg::cfg_t                cfg
);

  sffu_pkg::cfg_t     cfg_r;
  sffu_pkg::reg_idx_t idx;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = sffu_pkg::reg_idx_t'(cfg_paddr[sffu_pkg::CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg        = cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_flags     <= '0;
      cfg_r.right_limit    <= 16'sh7FFF;
      cfg_r.left_limit     <= 16'sh8000;
      cfg_r.target_angle   <= '0;
      cfg_r.constant_force <= '0;
      cfg_r.vib_amp        <= '0;
      cfg_r.phase_step     <= '0;
    end else if (wr_en) begin
      case (idx)
        sffu_pkg::REG_MODE_FLAGS:  cfg_r.mode_flags     <= cfg_pwdata[sffu_pkg::MODE_W-1:0];
        sffu_pkg::REG_RIGHT_LIMIT: cfg_r.right_limit    <= cfg_pwdata[sffu_pkg::DATA_W-1:0];
        sffu_pkg::REG_LEFT_LIMIT:  cfg_r.left_limit     <= cfg_pwdata[sffu_pkg::DATA_W-1:0];
        sffu_pkg::REG_TARGET:      cfg_r.target_angle   <= cfg_pwdata[sffu_pkg::DATA_W-1:0];
        sffu_pkg::REG_CONST_FORCE: cfg_r.constant_force <= cfg_pwdata[sffu_pkg::DATA_W-1:0];
        sffu_pkg::REG_VIB_AMP:     cfg_r.vib_amp        <= cfg_pwdata[sffu_pkg::AMP_W-1:0];
        sffu_pkg::REG_PHASE_STEP:  cfg_r.phase_step     <= cfg_pwdata[sffu_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, signed registers sign-extended
  always_comb begin
    case (idx)
      sffu_pkg::REG_MODE_FLAGS:  cfg_prdata = sffu_pkg::CFG_DW'(cfg_r.mode_flags);
      sffu_pkg::REG_RIGHT_LIMIT: cfg_prdata = sffu_pkg::CFG_DW'(cfg_r.right_limit);
      sffu_pkg::REG_LEFT_LIMIT:  cfg_prdata = sffu_pkg::CFG_DW'(cfg_r.left_limit);
      sffu_pkg::REG_TARGET:      cfg_prdata = sffu_pkg::CFG_DW'(cfg_r.target_angle);
      sffu_pkg::REG_CONST_FORCE: cfg_prdata = sffu_pkg::CFG_DW'(cfg_r.constant_force);
      sffu_pkg::REG_VIB_AMP:     cfg_prdata = sffu_pkg::CFG_DW'(cfg_r.vib_amp);
      sffu_pkg::REG_PHASE_STEP:  cfg_prdata = sffu_pkg::CFG_DW'(cfg_r.phase_step);
      default:                   cfg_prdata = '0;
    endcase
  end

endmodule

>>> src/sffu_vib.sv
// Vibration phase accumulator with registered sine table lookup.
module sffu_vib #(
  parameter int SINE_ENTRIES = sffu_pkg::SINE_ENTRIES_DEF,
  parameter int PHASE_BITS   = sffu_pkg::PHASE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              advance,
  input  logic [sffu_pkg::STEP_W-1:0]       phase_step,
  output logic signed [sffu_pkg::DATA_W-1:0] sine_q
);

  localparam int IDX_W = $clog2(SINE_ENTRIES);
  localparam int MUL_W = PHASE_BITS + IDX_W;

  logic [PHASE_BITS-1:0]             phase_r;
  logic [PHASE_BITS-1:0]             phase_nxt;
  logic [MUL_W-1:0]                  prod;
  logic [IDX_W-1:0]                  idx_nxt;
  logic signed [sffu_pkg::DATA_W-1:0] lut [SINE_ENTRIES];
  logic signed [sffu_pkg::DATA_W-1:0] sine_r;

  // Constant sine table, folded to the first half turn at elaboration
  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_lut
    localparam bit     NEG = (2 * k > SINE_ENTRIES);
    localparam longint IDX = NEG ? longint'(SINE_ENTRIES - k) : longint'(k);
    localparam longint ANG = (IDX * sffu_pkg::TWO_PI_Q28) / SINE_ENTRIES;
    assign lut[k] = sffu_pkg::sine_entry(ANG, NEG);
  end

  // Phase wraps modulo 2^PHASE_BITS; index = (phase * entries) >> PHASE_BITS
  assign phase_nxt = advance ? phase_r + PHASE_BITS'(phase_step) : phase_r;
  assign prod      = MUL_W'(phase_nxt) * MUL_W'(SINE_ENTRIES);
  assign idx_nxt   = prod[MUL_W-1 -: IDX_W];
  assign sine_q    = sine_r;

  // sine_r always holds the entry for the current phase (entry 0 is zero)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      sine_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      sine_r  <= lut[idx_nxt];
    end
  end

endmodule

>>> src/sffu_force.sv
// Force selection, vibration sum and saturation for one staged sample.
module sffu_force (
  input  sffu_pkg::cfg_t                    cfg,
  input  logic signed [sffu_pkg::DATA_W-1:0] steer,
  input  logic signed [sffu_pkg::DATA_W-1:0] center,
  input  logic signed [sffu_pkg::DATA_W-1:0] vib,
  output logic signed [sffu_pkg::DATA_W-1:0] force_q
);

  localparam int W = 22;
  localparam logic signed [W-1:0] SAT_HI = W'(sffu_pkg::FORCE_MAX);
  localparam logic signed [W-1:0] SAT_LO = W'(sffu_pkg::FORCE_MIN);

  logic signed [W-1:0] st, rl, ll, ta, cf, ce, vb;
  logic signed [W-1:0] dr, dl, base, sum;

  assign st = W'(steer);
  assign rl = W'(cfg.right_limit);
  assign ll = W'(cfg.left_limit);
  assign ta = W'(cfg.target_angle);
  assign cf = W'(cfg.constant_force);
  assign ce = W'(center);
  assign vb = W'(vib);
  assign dr = st - rl;
  assign dl = st - ll;

  // Wall force past a limit, else base force plus vibration
  always_comb begin
    if (cfg.mode_flags[sffu_pkg::MODE_HOLD]) begin
      base = (ta - st) <<< 1;
    end else if (cfg.mode_flags[sffu_pkg::MODE_CENTER] && cfg.constant_force == '0) begin
      base = ce;
    end else begin
      base = cf;
    end
    if (steer > cfg.right_limit) begin
      sum = (dr <<< 3) + dr;
    end else if (steer < cfg.left_limit) begin
      sum = (dl <<< 3) + dl;
    end else begin
      sum = base + vb;
    end
  end

  // Clamp to Q1.15
  always_comb begin
    if (sum > SAT_HI) begin
      force_q = SAT_HI[sffu_pkg::DATA_W-1:0];
    end else if (sum < SAT_LO) begin
      force_q = SAT_LO[sffu_pkg::DATA_W-1:0];
    end else begin
      force_q = sum[sffu_pkg::DATA_W-1:0];
    end
  end

endmodule
